>>> hdl/embd_pkg.sv
`timescale 1ns / 1ps

package embd_pkg;

  localparam int unsigned RAM_WORDS   = 65536;
  localparam logic [31:0] VIDEO_BASE  = 32'h8000_0000;
  localparam int unsigned VIDEO_WORDS = 76800;

  localparam int unsigned RAM_AW = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
  localparam int unsigned VID_AW = (VIDEO_WORDS > 1) ? $clog2(VIDEO_WORDS) : 1;

  // one clearing pass covers both stores
  localparam int unsigned CLR_N = (RAM_WORDS > VIDEO_WORDS) ? RAM_WORDS : VIDEO_WORDS;
  localparam int unsigned CLR_W = $clog2(CLR_N + 1);

  localparam logic [32:0] VIDEO_END = {1'b0, VIDEO_BASE} + 33'(VIDEO_WORDS) * 33'd4;

  localparam logic [31:0] FILL_WORD     = 32'h0D0D_0D0D;
  localparam int unsigned LEN_W         = 19;
  localparam logic [18:0] RAM_LEN_RESET = 19'd262144;

  localparam logic [1:0] ABORT_NONE     = 2'd0;
  localparam logic [1:0] ABORT_PREFETCH = 2'd1;
  localparam logic [1:0] ABORT_DATA     = 2'd2;

  typedef enum logic [2:0] {
    OP_FETCH32 = 3'd0,
    OP_FETCH16 = 3'd1,
    OP_READ32  = 3'd2,
    OP_READ16  = 3'd3,
    OP_READ8   = 3'd4,
    OP_WRITE32 = 3'd5,
    OP_WRITE16 = 3'd6,
    OP_WRITE8  = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

>>> hdl/embd_ram.sv
`timescale 1ns / 1ps

module embd_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/emulated_memory_bus_decoder_core.sv
`timescale 1ns / 1ps
// An accepted input beat moves ST_IDLE to ST_EXEC; the access executes once the
// output register is empty or drained, and its result beat is registered. A new beat is
// accepted only after the last access has executed; the RAM word is read at accept, then
// merged and written back. Reset: a clearing pass fills the RAM with 0x0D bytes and
// zeroes the frame buffer; no input beat is accepted until it ends.
module emulated_memory_bus_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [18:0] cfg_wdata_i,      // ram_length
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] address, [63:32] write_data
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] read_data
  output logic [2:0]  m_axis_tuser_o    // [1:0] abort_code, [2] screen_refresh
);
  import embd_pkg::*;

  state_e state_q, state_d;

  logic [LEN_W-1:0] ram_len_q;
  logic [CLR_W-1:0] clr_q, clr_d;

  // decoded access, captured at accept
  opcode_e         op_q;
  logic [31:0]     a_q;
  logic [31:0]     wd_q;
  logic            ok_q, vid_q, upd_q, above_q;
  logic [VID_AW-1:0] vidx_q;

  logic        m_valid_q;
  logic [31:0] rdata_q;
  logic [1:0]  abort_q;
  logic        refr_q;

  logic        accept, go;
  logic        ram_re, ram_we, vid_re, vid_we;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [VID_AW-1:0] vid_waddr, vid_raddr;
  logic [31:0] ram_wdata, vid_wdata, ram_rd, vid_rd;

  // input decode
  opcode_e     in_op;
  logic [31:0] in_addr, in_a;
  logic [32:0] in_a33, in_voff;
  logic        in_ok, in_vid, in_upd, in_above;

  always_comb begin
    in_op   = opcode_e'(s_axis_tuser_i);
    in_addr = s_axis_tdata_i[31:0];
    case (in_op)
      OP_FETCH32, OP_READ32, OP_WRITE32: in_a = {in_addr[31:2], 2'b00};
      OP_FETCH16, OP_READ16, OP_WRITE16: in_a = {in_addr[31:1], 1'b0};
      default:                           in_a = in_addr;
    endcase
    in_a33   = {1'b0, in_a};
    in_ok    = (in_a33 < 33'(ram_len_q)) && (in_a[31:2] < 30'(RAM_WORDS));
    in_vid   = (in_a33 >= {1'b0, VIDEO_BASE}) && (in_a33 < VIDEO_END);
    in_upd   = (in_a33 == VIDEO_END);
    in_above = (in_a33 > VIDEO_END);
    in_voff  = in_a33 - {1'b0, VIDEO_BASE};
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_len_q <= RAM_LEN_RESET;
    end else if (cfg_we_i) begin
      ram_len_q <= cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == CLR_W'(CLR_N - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (s_axis_tvalid_i) state_d = ST_EXEC;
      ST_EXEC:  if (!m_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    go              = 1'b0;
    clr_d           = clr_q;
    case (state_q)
      ST_CLEAR: clr_d = clr_q + CLR_W'(1);
      ST_IDLE:  s_axis_tready_o = 1'b1;
      ST_EXEC:  go = !m_valid_q || m_axis_tready_i;
      default:  clr_d = '0;
    endcase
  end

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_op;
      a_q     <= in_a;
      wd_q    <= s_axis_tdata_i[63:32];
      ok_q    <= in_ok;
      vid_q   <= in_vid;
      upd_q   <= in_upd;
      above_q <= in_above;
      vidx_q  <= in_voff[VID_AW+1:2];
    end
  end

  // execute: merge, result and write-back
  logic [4:0]  sh;
  logic [31:0] ram_shr, nmask, merged, res_data;
  logic [1:0]  res_abort;
  logic        res_refr, wr_ram, wr_vid;

  always_comb begin
    sh        = {a_q[1:0], 3'b000};
    ram_shr   = ram_rd >> sh;
    nmask     = (op_q == OP_WRITE16) ? 32'h0000_FFFF : 32'h0000_00FF;
    merged    = (ram_rd & ~(nmask << sh)) | ((wd_q & nmask) << sh);
    res_data  = '0;
    res_abort = ABORT_NONE;
    res_refr  = 1'b0;
    wr_ram    = 1'b0;
    wr_vid    = 1'b0;
    case (op_q)
      OP_FETCH32: begin
        res_data  = ok_q ? ram_rd : 32'hFFFF_FFFF;
        res_abort = ok_q ? ABORT_NONE : ABORT_PREFETCH;
      end
      OP_FETCH16: begin
        res_data  = ok_q ? (ram_shr & 32'h0000_FFFF) : 32'h0000_FFFF;
        res_abort = ok_q ? ABORT_NONE : ABORT_PREFETCH;
      end
      OP_READ32: begin
        if (vid_q) begin
          res_data = vid_rd;
        end else begin
          res_data  = ok_q ? ram_rd : 32'hFFFF_FFFF;
          res_abort = ok_q ? ABORT_NONE : ABORT_DATA;
        end
      end
      OP_READ16: begin
        res_data  = ok_q ? (ram_shr & 32'h0000_FFFF) : 32'h0000_FFFF;
        res_abort = ok_q ? ABORT_NONE : ABORT_DATA;
      end
      OP_READ8: begin
        res_data  = ok_q ? (ram_shr & 32'h0000_00FF) : 32'h0000_00FF;
        res_abort = ok_q ? ABORT_NONE : ABORT_DATA;
      end
      OP_WRITE32: begin
        if (vid_q) begin
          wr_vid = 1'b1;
        end else if (upd_q) begin
          res_refr = 1'b1;
        end else if (above_q || !ok_q) begin
          res_abort = ABORT_DATA;
        end else begin
          wr_ram = 1'b1;
        end
      end
      default: begin
        res_abort = ok_q ? ABORT_NONE : ABORT_DATA;
        wr_ram    = ok_q;
      end
    endcase
  end

  // memory ports: clearing pass owns the write ports after reset
  logic clr_on;
  always_comb begin
    clr_on    = (state_q == ST_CLEAR);
    ram_re    = accept;
    vid_re    = accept;
    ram_raddr = in_a[RAM_AW+1:2];
    vid_raddr = in_voff[VID_AW+1:2];
    if (clr_on) begin
      ram_we    = clr_q < CLR_W'(RAM_WORDS);
      ram_waddr = clr_q[RAM_AW-1:0];
      ram_wdata = FILL_WORD;
      vid_we    = clr_q < CLR_W'(VIDEO_WORDS);
      vid_waddr = clr_q[VID_AW-1:0];
      vid_wdata = '0;
    end else begin
      ram_we    = go && wr_ram;
      ram_waddr = a_q[RAM_AW+1:2];
      ram_wdata = (op_q == OP_WRITE32) ? wd_q : merged;
      vid_we    = go && wr_vid;
      vid_waddr = vidx_q;
      vid_wdata = wd_q;
    end
  end

  embd_ram #(.DEPTH(RAM_WORDS), .WIDTH(32), .AW(RAM_AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rd)
  );

  embd_ram #(.DEPTH(VIDEO_WORDS), .WIDTH(32), .AW(VID_AW)) u_frame (
    .clk_i   (clk_i),
    .we_i    (vid_we),
    .waddr_i (vid_waddr),
    .wdata_i (vid_wdata),
    .re_i    (vid_re),
    .raddr_i (vid_raddr),
    .rdata_o (vid_rd)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (go) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      rdata_q <= res_data;
      abort_q <= res_abort;
      refr_q  <= res_refr;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = rdata_q;
  assign m_axis_tuser_o  = {refr_q, abort_q};

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready_o)
    else $error("input accepted during clearing pass");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result beat without an executed access");

  a_refresh_no_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(refr_q && (abort_q != ABORT_NONE)))
    else $error("refresh and abort in one beat");

  a_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we || vid_we) |-> (state_q != ST_IDLE))
    else $error("store written while idle");

endmodule
